/* design/rds_pkg.sv */
`timescale 1ns / 1ps

package rds_pkg;

    // Table geometry
    localparam int DEPTH = 16;
    localparam int IW    = 4;
    localparam int CW    = 5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CANCEL,
        S_PICK,
        S_EMIT
    } t_state;

    // Commands
    localparam logic [2:0] CMD_ENQUEUE    = 3'd0;
    localparam logic [2:0] CMD_LIST_READY = 3'd1;
    localparam logic [2:0] CMD_SUBMIT     = 3'd2;
    localparam logic [2:0] CMD_COMPLETE   = 3'd3;
    localparam logic [2:0] CMD_FAIL       = 3'd4;
    localparam logic [2:0] CMD_CANCEL     = 3'd5;
    localparam logic [2:0] CMD_CANCEL_ALL = 3'd6;
    localparam logic [2:0] CMD_TAKE       = 3'd7;

    // Result status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_ZERO_ID      = 4'd1;
    localparam logic [3:0] ST_DUPLICATE    = 4'd2;
    localparam logic [3:0] ST_OUT_OF_ORDER = 4'd3;
    localparam logic [3:0] ST_BACKPRESSURE = 4'd4;
    localparam logic [3:0] ST_UNKNOWN      = 4'd5;
    localparam logic [3:0] ST_NOT_READY    = 4'd6;
    localparam logic [3:0] ST_BAD_TRANS    = 4'd7;
    localparam logic [3:0] ST_RESP_PENDING = 4'd8;

    // Entry states
    localparam logic [2:0] ES_QUEUED    = 3'd0;
    localparam logic [2:0] ES_SUBMITTED = 3'd1;
    localparam logic [2:0] ES_COMPLETED = 3'd2;
    localparam logic [2:0] ES_FAILED    = 3'd3;
    localparam logic [2:0] ES_CANCELLED = 3'd4;

    // Register indexes
    localparam logic REG_MAX_OUTSTANDING = 1'b0;

    // One result record handed to the output stage
    typedef struct packed {
        logic [3:0]       status;
        logic             has_entry;
        logic [63:0]      id;
        logic [31:0]      stream;
        logic             sync;
        logic [2:0]       state;
        logic [31:0]      code;
        logic [DEPTH-1:0] wait_mask;
        logic [CW-1:0]    outstanding;
        logic             last;
    } t_rec;

endpackage

/* design/request_dependency_scoreboard.sv */
`timescale 1ns / 1ps

// Request dependency scoreboard: a 16-slot table of outstanding requests with
// per-slot dependency masks, driven by one command item at a time. A single
// sequencer walks the slots one per cycle through one shared slot read index.
// Enqueue, submit, complete, fail, cancel and take response scan the table
// once, then pass through a decide step and an emit step; fail and cancel
// also walk the cancel cascade, cancelling the live dependents of one source
// at a time. List ready and cancel all run a minimum search over the table
// for every reported entry, so entries are listed in ascending id order.
// The input is stalled while an item is in work; a finished result sits in an
// output register until taken. max_outstanding lives at byte address 0.
module request_dependency_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_req_id,
    input  logic [31:0] i_stream,
    input  logic        i_is_device_sync,
    input  logic signed [31:0] i_done_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic        o_has_entry,
    output logic [63:0] o_entry_id,
    output logic [31:0] o_entry_stream,
    output logic        o_entry_sync,
    output logic [2:0]  o_entry_state,
    output logic signed [31:0] o_entry_code,
    output logic [4:0]  o_pending_deps,
    output logic [4:0]  o_outstanding,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rds_pkg::*;

    t_state r_state, n_state;

    // Slot table
    logic [DEPTH-1:0] r_valid, n_valid;
    logic [63:0]      r_id     [DEPTH];
    logic [63:0]      n_id     [DEPTH];
    logic [31:0]      r_strm   [DEPTH];
    logic [31:0]      n_strm   [DEPTH];
    logic [DEPTH-1:0] r_syncf, n_syncf;
    logic [2:0]       r_stat   [DEPTH];
    logic [2:0]       n_stat   [DEPTH];
    logic [31:0]      r_codes  [DEPTH];
    logic [31:0]      n_codes  [DEPTH];
    logic [DEPTH-1:0] r_wait   [DEPTH];
    logic [DEPTH-1:0] n_wait   [DEPTH];
    logic [DEPTH-1:0] r_tail, n_tail;
    logic             r_bar_v, n_bar_v;
    logic [IW-1:0]    r_bar_slot, n_bar_slot;
    logic [63:0]      r_last_id, n_last_id;
    logic [CW-1:0]    r_count, n_count;
    logic [4:0]       r_max;

    // Captured item and sequencer working registers
    logic [2:0]       r_cmd, n_cmd;
    logic [63:0]      r_rid, n_rid;
    logic [31:0]      r_stream, n_stream;
    logic             r_sync, n_sync;
    logic [31:0]      r_code, n_code;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_found, n_found;
    logic [IW-1:0]    r_slot, n_slot;
    logic [DEPTH-1:0] r_tmatch, n_tmatch;
    logic [DEPTH-1:0] r_sel, n_sel;
    logic [DEPTH-1:0] r_todo, n_todo;
    logic [IW-1:0]    r_best, n_best;
    logic [63:0]      r_best_id, n_best_id;
    logic             r_best_ok, n_best_ok;
    logic [3:0]       r_status, n_status;
    logic             r_has, n_has;
    logic             r_lastf, n_lastf;

    logic             n_load;
    logic             out_ready;
    t_rec             rec;

    logic [DEPTH-1:0] live, ready_vec, hit;
    logic [IW-1:0]    free_idx, todo_idx, nb;
    logic             free_ok, cand;
    logic [63:0]      cur_id;
    logic [2:0]       cur_stat;
    logic [DEPTH-1:0] cur_wait;

    // Read the addressed slot through one shared index
    assign cur_id   = r_id[r_idx];
    assign cur_stat = r_stat[r_idx];
    assign cur_wait = r_wait[r_idx];

    // Per-slot liveness and readiness
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            live[i]      = r_valid[i] && (r_stat[i] < ES_COMPLETED);
            ready_vec[i] = r_valid[i] && (r_stat[i] == ES_QUEUED) && (r_wait[i] == '0);
        end
    end

    // Lowest free slot and lowest pending cancel source
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        todo_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
                free_ok  = 1'b1;
            end
            if (r_todo[i]) begin
                todo_idx = IW'(i);
            end
        end
    end

    // Sequencer: next state and table updates
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_id       = r_id;
        n_strm     = r_strm;
        n_syncf    = r_syncf;
        n_stat     = r_stat;
        n_codes    = r_codes;
        n_wait     = r_wait;
        n_tail     = r_tail;
        n_bar_v    = r_bar_v;
        n_bar_slot = r_bar_slot;
        n_last_id  = r_last_id;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_rid      = r_rid;
        n_stream   = r_stream;
        n_sync     = r_sync;
        n_code     = r_code;
        n_idx      = r_idx;
        n_found    = r_found;
        n_slot     = r_slot;
        n_tmatch   = r_tmatch;
        n_sel      = r_sel;
        n_todo     = r_todo;
        n_best     = r_best;
        n_best_id  = r_best_id;
        n_best_ok  = r_best_ok;
        n_status   = r_status;
        n_has      = r_has;
        n_lastf    = r_lastf;
        n_load     = 1'b0;
        hit        = '0;
        cand       = 1'b0;
        nb         = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_command;
                    n_rid     = i_req_id;
                    n_stream  = i_stream;
                    n_sync    = i_is_device_sync;
                    n_code    = i_done_code;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_tmatch  = '0;
                    n_best_ok = 1'b0;
                    if (i_command == CMD_LIST_READY) begin
                        n_sel   = ready_vec;
                        n_state = S_PICK;
                    end else if (i_command == CMD_CANCEL_ALL) begin
                        // Cancel every live entry at once and list them
                        for (int i = 0; i < DEPTH; i++) begin
                            if (live[i]) begin
                                n_stat[i] = ES_CANCELLED;
                            end
                        end
                        n_sel   = live;
                        n_tail  = '0;
                        n_bar_v = 1'b0;
                        n_state = S_PICK;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Look up the id and collect stream tails, one slot a cycle
                if (r_valid[r_idx] && (cur_id == r_rid)) begin
                    n_found = 1'b1;
                    n_slot  = r_idx;
                end
                if (r_valid[r_idx] && r_tail[r_idx] && (r_strm[r_idx] == r_stream)) begin
                    n_tmatch[r_idx] = 1'b1;
                end
                if (r_idx == IW'(DEPTH - 1)) begin
                    n_idx   = n_found ? n_slot : '0;
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_DECIDE: begin
                n_lastf  = 1'b1;
                n_has    = 1'b1;
                n_status = ST_OK;
                n_state  = S_EMIT;
                if (r_cmd == CMD_ENQUEUE) begin
                    n_has = 1'b0;
                    if (r_rid == 64'd0) begin
                        n_status = ST_ZERO_ID;
                    end else if (r_found) begin
                        n_status = ST_DUPLICATE;
                    end else if (r_rid <= r_last_id) begin
                        n_status = ST_OUT_OF_ORDER;
                    end else if ((r_count >= r_max) || !free_ok) begin
                        n_status = ST_BACKPRESSURE;
                    end else begin
                        // Install the request in the lowest free slot
                        n_wait[free_idx] = '0;
                        if (r_bar_v) begin
                            n_wait[free_idx][r_bar_slot] = 1'b1;
                        end
                        if (r_sync) begin
                            n_wait[free_idx] = n_wait[free_idx] | live;
                            n_bar_v          = 1'b1;
                            n_bar_slot       = free_idx;
                            n_tail[free_idx] = 1'b0;
                        end else begin
                            n_wait[free_idx] = n_wait[free_idx] | r_tmatch;
                            n_tail           = r_tail & ~r_tmatch;
                            n_tail[free_idx] = 1'b1;
                        end
                        n_valid[free_idx] = 1'b1;
                        n_id[free_idx]    = r_rid;
                        n_strm[free_idx]  = r_stream;
                        n_syncf[free_idx] = r_sync;
                        n_stat[free_idx]  = ES_QUEUED;
                        n_codes[free_idx] = 32'd0;
                        n_last_id         = r_rid;
                        n_count           = r_count + 1'b1;
                        n_idx             = free_idx;
                        n_has             = 1'b1;
                    end
                end else if (!r_found) begin
                    n_has    = 1'b0;
                    n_status = ST_UNKNOWN;
                end else begin
                    unique case (r_cmd)
                        CMD_SUBMIT: begin
                            if (cur_stat != ES_QUEUED) begin
                                n_status = ST_BAD_TRANS;
                            end else if (cur_wait != '0) begin
                                n_status = ST_NOT_READY;
                            end else begin
                                n_stat[r_idx] = ES_SUBMITTED;
                            end
                        end
                        CMD_COMPLETE: begin
                            if (cur_stat != ES_SUBMITTED) begin
                                n_status = ST_BAD_TRANS;
                            end else begin
                                n_stat[r_idx]  = ES_COMPLETED;
                                n_codes[r_idx] = r_code;
                                for (int i = 0; i < DEPTH; i++) begin
                                    n_wait[i][r_idx] = 1'b0;
                                end
                                n_tail[r_idx] = 1'b0;
                                if (r_bar_v && (r_bar_slot == r_idx)) begin
                                    n_bar_v = 1'b0;
                                end
                            end
                        end
                        CMD_FAIL, CMD_CANCEL: begin
                            if ((r_cmd == CMD_FAIL) ? (cur_stat != ES_SUBMITTED)
                                                    : (cur_stat >= ES_COMPLETED)) begin
                                n_status = ST_BAD_TRANS;
                            end else begin
                                if (r_cmd == CMD_FAIL) begin
                                    n_stat[r_idx]  = ES_FAILED;
                                    n_codes[r_idx] = r_code;
                                end else begin
                                    n_stat[r_idx] = ES_CANCELLED;
                                end
                                n_tail[r_idx] = 1'b0;
                                if (r_bar_v && (r_bar_slot == r_idx)) begin
                                    n_bar_v = 1'b0;
                                end
                                n_todo          = '0;
                                n_todo[r_idx]   = 1'b1;
                                n_state         = S_CANCEL;
                            end
                        end
                        default: begin
                            // Take response: remove a finished entry
                            if (cur_stat < ES_COMPLETED) begin
                                n_status = ST_RESP_PENDING;
                            end else begin
                                n_valid[r_idx] = 1'b0;
                                n_tail[r_idx]  = 1'b0;
                                for (int i = 0; i < DEPTH; i++) begin
                                    n_wait[i][r_idx] = 1'b0;
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_CANCEL: begin
                // Cancel live dependents of one source a cycle
                if (r_todo == '0) begin
                    n_state = S_EMIT;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (live[i] && r_wait[i][todo_idx]) begin
                            hit[i]    = 1'b1;
                            n_stat[i] = ES_CANCELLED;
                            n_tail[i] = 1'b0;
                        end
                    end
                    if (r_bar_v && hit[r_bar_slot]) begin
                        n_bar_v = 1'b0;
                    end
                    n_todo           = r_todo | hit;
                    n_todo[todo_idx] = 1'b0;
                end
            end

            S_PICK: begin
                if (r_sel == '0) begin
                    // Empty listing
                    n_has    = 1'b0;
                    n_lastf  = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                end else begin
                    // Search the smallest selected id, one slot a cycle
                    cand = r_sel[r_idx] && (!r_best_ok || (cur_id < r_best_id));
                    if (cand) begin
                        n_best    = r_idx;
                        n_best_id = cur_id;
                        n_best_ok = 1'b1;
                        nb        = r_idx;
                    end
                    if (r_idx == IW'(DEPTH - 1)) begin
                        n_sel[nb] = 1'b0;
                        n_lastf   = (n_sel == '0);
                        n_idx     = nb;
                        n_has     = 1'b1;
                        n_status  = ST_OK;
                        n_state   = S_EMIT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_EMIT: begin
                if (out_ready) begin
                    n_load = 1'b1;
                    if (r_lastf) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx     = '0;
                        n_best_ok = 1'b0;
                        n_state   = S_PICK;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_tail     <= '0;
            r_bar_v    <= 1'b0;
            r_bar_slot <= '0;
            r_last_id  <= 64'd0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_tail     <= n_tail;
            r_bar_v    <= n_bar_v;
            r_bar_slot <= n_bar_slot;
            r_last_id  <= n_last_id;
            r_count    <= n_count;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_strm    <= n_strm;
        r_syncf   <= n_syncf;
        r_stat    <= n_stat;
        r_codes   <= n_codes;
        r_wait    <= n_wait;
        r_cmd     <= n_cmd;
        r_rid     <= n_rid;
        r_stream  <= n_stream;
        r_sync    <= n_sync;
        r_code    <= n_code;
        r_idx     <= n_idx;
        r_found   <= n_found;
        r_slot    <= n_slot;
        r_tmatch  <= n_tmatch;
        r_sel     <= n_sel;
        r_todo    <= n_todo;
        r_best    <= n_best;
        r_best_id <= n_best_id;
        r_best_ok <= n_best_ok;
        r_status  <= n_status;
        r_has     <= n_has;
        r_lastf   <= n_lastf;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 5'd16;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_OUTSTANDING)) begin
            r_max <= pwdata[4:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_MAX_OUTSTANDING) ? {27'd0, r_max} : 32'd0;
    assign o_in_stall = (r_state != S_IDLE);

    // Assemble the record of the addressed slot
    always_comb begin
        rec.status      = r_status;
        rec.has_entry   = r_has;
        rec.id          = cur_id;
        rec.stream      = r_strm[r_idx];
        rec.sync        = r_syncf[r_idx];
        rec.state       = cur_stat;
        rec.code        = r_codes[r_idx];
        rec.wait_mask   = cur_wait;
        rec.outstanding = r_count;
        rec.last        = r_lastf;
    end

    rds_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (n_load),
        .i_rec          (rec),
        .i_out_stall    (i_out_stall),
        .o_ready        (out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_has_entry    (o_has_entry),
        .o_entry_id     (o_entry_id),
        .o_entry_stream (o_entry_stream),
        .o_entry_sync   (o_entry_sync),
        .o_entry_state  (o_entry_state),
        .o_entry_code   (o_entry_code),
        .o_pending_deps (o_pending_deps),
        .o_outstanding  (o_outstanding),
        .o_last         (o_last)
    );

    // Occupancy counter tracks the valid bits
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("occupancy count out of step with valid bits");

    // A stream tail is always a held entry
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail & ~r_valid) == '0)
        else $error("stream tail on an empty slot");

    // The barrier points at a held entry
    a_barrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bar_v |-> r_valid[r_bar_slot])
        else $error("barrier on an empty slot");

    // A drained cancel list moves on to the result
    a_cancel_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CANCEL) && (r_todo == '0) |=> (r_state == S_EMIT))
        else $error("cancel walk did not finish");

endmodule

/* design/rds_out_stage.sv */
`timescale 1ns / 1ps

module rds_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  rds_pkg::t_rec i_rec,
    input  logic          i_out_stall,
    output logic          o_ready,
    output logic          o_out_valid,
    output logic [3:0]    o_status,
    output logic          o_has_entry,
    output logic [63:0]   o_entry_id,
    output logic [31:0]   o_entry_stream,
    output logic          o_entry_sync,
    output logic [2:0]    o_entry_state,
    output logic [31:0]   o_entry_code,
    output logic [4:0]    o_pending_deps,
    output logic [4:0]    o_outstanding,
    output logic          o_last
);
    import rds_pkg::*;

    logic r_valid;
    logic [4:0] n_deps;

    // Count unresolved dependencies of the record
    assign n_deps = 5'($countones(i_rec.wait_mask));

    // Take a new item when the register is empty or being drained
    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // Hold the payload; blank the entry fields when no entry is reported
    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            o_status       <= i_rec.status;
            o_has_entry    <= i_rec.has_entry;
            o_entry_id     <= i_rec.has_entry ? i_rec.id     : 64'd0;
            o_entry_stream <= i_rec.has_entry ? i_rec.stream : 32'd0;
            o_entry_sync   <= i_rec.has_entry && i_rec.sync;
            o_entry_state  <= i_rec.has_entry ? i_rec.state  : 3'd0;
            o_entry_code   <= i_rec.has_entry ? i_rec.code   : 32'd0;
            o_pending_deps <= i_rec.has_entry ? n_deps       : 5'd0;
            o_outstanding  <= i_rec.outstanding;
            o_last         <= i_rec.last;
        end
    end

endmodule
